/* src/dipt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipt_pkg: shared types and constants for the pan-tilt controller
// Frame geometry, score scaling, register indexes and reset values.
// ----------------------------------------------------------------------------
package dipt_pkg;

  localparam int unsigned FRAME_WIDTH  = 640;
  localparam int unsigned FRAME_HEIGHT = 480;

  localparam logic [11:0] HALF_W = 12'(FRAME_WIDTH / 2);
  localparam logic [11:0] HALF_H = 12'(FRAME_HEIGHT / 2);

  // Q8 score scale: full deflection is 100 * 256
  localparam logic [14:0] SCORE_FULL  = 15'd25600;
  localparam logic [14:0] DEADBAND_Q8 = 15'd5120;

  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 19;

  localparam logic [CFG_IDX_W-1:0] REG_MOVE_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_LOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_HIGH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_HIGH    = 3'd6;

  localparam logic [15:0]        RST_MOVE_INTERVAL = 16'd100;
  localparam logic [13:0]        RST_GAIN          = 14'd1000;
  localparam logic signed [18:0] RST_LOW_LIMIT     = -19'sd90000;
  localparam logic signed [18:0] RST_HIGH_LIMIT    = 19'sd90000;

  typedef enum logic {
    DIV_SCORE,
    DIV_PCT
  } div_mode_e;

  typedef struct packed {
    logic [13:0]        gain;
    logic signed [18:0] lo;
    logic signed [18:0] hi;
  } axis_cfg_t;

endpackage

/* src/dipt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipt_if: channel interfaces of the pan-tilt controller
// Input item channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface dipt_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        matched;
  logic [11:0] x_pixel;
  logic [11:0] y_pixel;

  modport source (output valid, kind, matched, x_pixel, y_pixel, input ready);
  modport sink   (input valid, kind, matched, x_pixel, y_pixel, output ready);
endinterface

interface dipt_out_if;
  logic               valid;
  logic               ready;
  logic [6:0]         yaw_pwm_percent;
  logic [6:0]         pitch_pwm_percent;
  logic signed [18:0] yaw_angle;
  logic signed [18:0] pitch_angle;

  modport source (output valid, yaw_pwm_percent, pitch_pwm_percent, yaw_angle,
                  pitch_angle, input ready);
  modport sink   (input valid, yaw_pwm_percent, pitch_pwm_percent, yaw_angle,
                  pitch_angle, output ready);
endinterface

interface dipt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [18:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/dipt_sdiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipt_sdiv: bit-serial restoring divider
// One quotient bit per cycle: 15 bits for the score, 7 bits for the percent.
// ----------------------------------------------------------------------------
module dipt_sdiv
  import dipt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  div_mode_e   mode_i,
  input  logic [25:0] num_i,
  input  logic [18:0] den_i,
  output logic        busy_o,
  output logic [14:0] quot_o
);

  logic [3:0]  cnt_q, cnt_d;
  logic [19:0] rem_q, rem_d;
  logic [14:0] low_q, low_d;
  logic [14:0] quot_q, quot_d;
  logic [18:0] den_q, den_d;
  logic [20:0] trial;
  logic        ge;

  assign trial = {rem_q, low_q[14]};
  assign ge    = trial >= {2'b00, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    den_d  = den_q;
    if (start_i) begin
      den_d  = den_i;
      quot_d = '0;
      // pre-align so that only the quotient bits that can be set are produced
      if (mode_i == DIV_SCORE) begin
        rem_d = {9'd0, num_i[25:15]};
        low_d = num_i[14:0];
        cnt_d = 4'd15;
      end else begin
        rem_d = {1'b0, num_i[25:7]};
        low_d = {num_i[6:0], 8'd0};
        cnt_d = 4'd7;
      end
    end else if (cnt_q != 4'd0) begin
      rem_d  = ge ? 20'(trial - {2'b00, den_q}) : trial[19:0];
      quot_d = {quot_q[13:0], ge};
      low_d  = {low_q[13:0], 1'b0};
      cnt_d  = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign busy_o = cnt_q != 4'd0;
  assign quot_o = quot_q;

endmodule

/* src/dipt_smul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipt_smul: bit-serial shift-add multiplier
// Gain times score magnitude, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dipt_smul
  import dipt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [13:0] a_i,
  input  logic [14:0] b_i,
  output logic        busy_o,
  output logic [28:0] prod_o
);

  logic [3:0]  cnt_q, cnt_d;
  logic [29:0] p_q, p_d;
  logic [13:0] a_q, a_d;
  logic [15:0] sum;

  assign sum = {1'b0, p_q[29:15]} + (p_q[0] ? {2'b00, a_q} : 16'd0);

  always_comb begin
    cnt_d = cnt_q;
    p_d   = p_q;
    a_d   = a_q;
    if (start_i) begin
      a_d   = a_i;
      p_d   = {15'd0, b_i};
      cnt_d = 4'd15;
    end else if (cnt_q != 4'd0) begin
      // add into the upper half, then shift the whole word right
      p_d   = {sum, p_q[14:1]};
      cnt_d = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    a_q <= a_d;
  end

  assign busy_o = cnt_q != 4'd0;
  assign prod_o = p_q[28:0];

endmodule

/* src/dipt_axis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipt_axis: one axis of the tracking loop
// Score, deadband, integral step, clamp and percent of span, sequenced over
// a serial divider and a serial multiplier.
// ----------------------------------------------------------------------------
module dipt_axis
  import dipt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [11:0]        pixel_i,
  input  logic [11:0]        half_i,
  input  axis_cfg_t          cfg_i,
  output logic               busy_o,
  output logic signed [18:0] angle_o,
  output logic [6:0]         pct_o
);

  localparam logic [2:0] AX_IDLE   = 3'd0;
  localparam logic [2:0] AX_SCORE  = 3'd1;
  localparam logic [2:0] AX_MUL_GO = 3'd2;
  localparam logic [2:0] AX_MUL    = 3'd3;
  localparam logic [2:0] AX_CLAMP  = 3'd4;
  localparam logic [2:0] AX_PCT_GO = 3'd5;
  localparam logic [2:0] AX_PCT    = 3'd6;

  logic [2:0]         state_q, state_d;
  logic               neg_q, neg_d;
  logic [14:0]        score_q, score_d;
  logic [20:0]        step_q, step_d;
  logic signed [18:0] held_q, held_d;
  logic [6:0]         pct_q, pct_d;

  logic               div_start, div_busy;
  div_mode_e          div_mode;
  logic [25:0]        div_num;
  logic [18:0]        div_den;
  logic [14:0]        div_quot;
  logic               mul_start, mul_busy;
  logic [28:0]        mul_prod;

  logic signed [12:0] diff;
  logic [11:0]        mag;
  logic [25:0]        mag_x;
  logic signed [22:0] step_x, sum, sum_c, lo_x, hi_x;
  logic signed [19:0] span, offs;
  logic [25:0]        offs_x;

  assign diff  = $signed({1'b0, pixel_i}) - $signed({1'b0, half_i});
  assign mag   = diff[12] ? 12'(-diff) : diff[11:0];
  assign mag_x = {14'd0, mag};

  assign step_x = neg_q ? -$signed({2'b00, step_q}) : $signed({2'b00, step_q});
  assign lo_x   = 23'(cfg_i.lo);
  assign hi_x   = 23'(cfg_i.hi);
  assign sum    = 23'(held_q) + step_x;

  // low limit first, then high, so a reversed pair ends on the high limit
  always_comb begin
    sum_c = sum;
    if (sum_c < lo_x) begin
      sum_c = lo_x;
    end
    if (sum_c > hi_x) begin
      sum_c = hi_x;
    end
  end

  assign span   = 20'(cfg_i.hi) - 20'(cfg_i.lo);
  assign offs   = 20'(held_q) - 20'(cfg_i.lo);
  assign offs_x = {7'd0, offs[18:0]};

  always_comb begin
    state_d   = state_q;
    neg_d     = neg_q;
    score_d   = score_q;
    step_d    = step_q;
    held_d    = held_q;
    pct_d     = pct_q;
    div_start = 1'b0;
    div_mode  = DIV_SCORE;
    div_num   = (mag_x << 14) + (mag_x << 13) + (mag_x << 10);
    div_den   = {7'd0, half_i};
    mul_start = 1'b0;
    case (state_q)
      AX_IDLE: begin
        if (start_i) begin
          neg_d = diff[12];
          if (mag >= half_i) begin
            score_d = SCORE_FULL;
            state_d = AX_MUL_GO;
          end else begin
            div_start = 1'b1;
            state_d   = AX_SCORE;
          end
        end
      end
      AX_SCORE: begin
        if (!div_busy) begin
          score_d = div_quot;
          state_d = AX_MUL_GO;
        end
      end
      AX_MUL_GO: begin
        if (score_q > DEADBAND_Q8) begin
          mul_start = 1'b1;
          state_d   = AX_MUL;
        end else begin
          step_d  = '0;
          state_d = AX_CLAMP;
        end
      end
      AX_MUL: begin
        if (!mul_busy) begin
          step_d  = mul_prod[28:8];
          state_d = AX_CLAMP;
        end
      end
      AX_CLAMP: begin
        held_d  = sum_c[18:0];
        state_d = AX_PCT_GO;
      end
      AX_PCT_GO: begin
        if (span[19] || span == 20'sd0) begin
          pct_d   = '0;
          state_d = AX_IDLE;
        end else begin
          div_start = 1'b1;
          div_mode  = DIV_PCT;
          div_num   = (offs_x << 6) + (offs_x << 5) + (offs_x << 2);
          div_den   = span[18:0];
          state_d   = AX_PCT;
        end
      end
      AX_PCT: begin
        if (!div_busy) begin
          pct_d   = div_quot[6:0];
          state_d = AX_IDLE;
        end
      end
      default: begin
        state_d = AX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AX_IDLE;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    score_q <= score_d;
    step_q  <= step_d;
    pct_q   <= pct_d;
  end

  dipt_sdiv u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mode_i  (div_mode),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  dipt_smul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (cfg_i.gain),
    .b_i     (score_q),
    .busy_o  (mul_busy),
    .prod_o  (mul_prod)
  );

  assign busy_o  = state_q != AX_IDLE;
  assign angle_o = held_q;
  assign pct_o   = pct_q;

endmodule

/* src/deadband_integral_pan_tilt_control.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadband_integral_pan_tilt_control: pan-tilt tracking controller
// Tick counter, move-interval gate, two axis lanes and a result register.
// ----------------------------------------------------------------------------
// A tick item and a detection that is gated off or unmatched leave the
// controller idle and ready for the next item. A matched detection runs
// both axes side by side, and each lane passes through its bit-serial score
// divider (skipped when the target is at or beyond the frame edge), its
// bit-serial gain multiplier (skipped inside the deadband) and a division
// for the percent output. The result sits in an output register, so the
// next item is taken while it waits; a second matched detection holds its
// lanes' result until that register is free. Registers are written at any
// time through the write channel, which is always ready; write them only
// while no item is in flight.
module deadband_integral_pan_tilt_control
  import dipt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  dipt_in_if.sink  in_i,
  dipt_out_if.source out_o,
  dipt_cfg_if.sink cfg_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state_q, state_d;
  logic [16:0]        elapsed_q, elapsed_d;
  logic [15:0]        interval_q;
  logic [13:0]        yaw_gain_q, pitch_gain_q;
  logic signed [18:0] yaw_lo_q, yaw_hi_q, pitch_lo_q, pitch_hi_q;

  logic               out_valid_q;
  logic [6:0]         yaw_pct_q, pitch_pct_q;
  logic signed [18:0] yaw_ang_q, pitch_ang_q;

  logic               in_acc, lane_start, load;
  logic               yaw_busy, pitch_busy;
  logic signed [18:0] yaw_ang, pitch_ang;
  logic [6:0]         yaw_pct, pitch_pct;
  axis_cfg_t          yaw_cfg, pitch_cfg;

  assign in_i.ready  = state_q == ST_IDLE;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign load = (state_q == ST_RUN) && !yaw_busy && !pitch_busy &&
                (!out_valid_q || out_o.ready);

  always_comb begin
    state_d    = state_q;
    elapsed_d  = elapsed_q;
    lane_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_i.kind) begin
            if (elapsed_q != ELAPSED_MAX) begin
              elapsed_d = elapsed_q + 17'd1;
            end
          end else if (elapsed_q > {1'b0, interval_q}) begin
            elapsed_d = '0;
            if (in_i.matched) begin
              lane_start = 1'b1;
              state_d    = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      elapsed_q <= '0;
    end else begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= RST_MOVE_INTERVAL;
      yaw_gain_q   <= RST_GAIN;
      pitch_gain_q <= RST_GAIN;
      yaw_lo_q     <= RST_LOW_LIMIT;
      yaw_hi_q     <= RST_HIGH_LIMIT;
      pitch_lo_q   <= RST_LOW_LIMIT;
      pitch_hi_q   <= RST_HIGH_LIMIT;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MOVE_INTERVAL: interval_q   <= cfg_i.data[15:0];
        REG_YAW_GAIN:      yaw_gain_q   <= cfg_i.data[13:0];
        REG_PITCH_GAIN:    pitch_gain_q <= cfg_i.data[13:0];
        REG_YAW_LOW:       yaw_lo_q     <= cfg_i.data;
        REG_YAW_HIGH:      yaw_hi_q     <= cfg_i.data;
        REG_PITCH_LOW:     pitch_lo_q   <= cfg_i.data;
        REG_PITCH_HIGH:    pitch_hi_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // hold the result until the consumer takes the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      yaw_pct_q   <= yaw_pct;
      pitch_pct_q <= pitch_pct;
      yaw_ang_q   <= yaw_ang;
      pitch_ang_q <= pitch_ang;
    end
  end

  assign yaw_cfg   = '{gain: yaw_gain_q, lo: yaw_lo_q, hi: yaw_hi_q};
  assign pitch_cfg = '{gain: pitch_gain_q, lo: pitch_lo_q, hi: pitch_hi_q};

  dipt_axis u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .pixel_i (in_i.x_pixel),
    .half_i  (HALF_W),
    .cfg_i   (yaw_cfg),
    .busy_o  (yaw_busy),
    .angle_o (yaw_ang),
    .pct_o   (yaw_pct)
  );

  dipt_axis u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .pixel_i (in_i.y_pixel),
    .half_i  (HALF_H),
    .cfg_i   (pitch_cfg),
    .busy_o  (pitch_busy),
    .angle_o (pitch_ang),
    .pct_o   (pitch_pct)
  );

  assign out_o.valid             = out_valid_q;
  assign out_o.yaw_pwm_percent   = yaw_pct_q;
  assign out_o.pitch_pwm_percent = pitch_pct_q;
  assign out_o.yaw_angle         = yaw_ang_q;
  assign out_o.pitch_angle       = pitch_ang_q;

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (yaw_pct_q <= 7'd100 && pitch_pct_q <= 7'd100))
    else $error("percent output above 100");

  a_tick_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_i.kind) |=> (state_q == ST_IDLE && !yaw_busy && !pitch_busy))
    else $error("tick transaction started the axis lanes");

  a_lanes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!yaw_busy && !pitch_busy))
    else $error("input ready while an axis lane is busy");

  a_yaw_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && yaw_lo_q <= yaw_hi_q) |->
      (yaw_ang_q >= yaw_lo_q && yaw_ang_q <= yaw_hi_q))
    else $error("yaw angle outside its limits");

endmodule

/* tb/deadband_integral_pan_tilt_control_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadband_integral_pan_tilt_control_test: self-checking bench for the
// pan-tilt tracking controller
// Drives tick and detection transactions with random gaps, stalls the result
// side at random and once for a long stretch, and checks every result against
// a cycle-free model of the tick counter, move gate, deadband, integrator,
// clamp and percent scaling. Runs directed corner cases first, then a short
// gate check with junk above the 16-bit interval, then random register
// settings with mostly well-formed tick-then-detect sequences.
// ----------------------------------------------------------------------------
module deadband_integral_pan_tilt_control_test
  import dipt_pkg::*;
();

  localparam int CLK_PERIOD    = 8;
  localparam int SETTLE_CYCLES = 100;
  localparam int IDLE_PERCENT  = 27;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_DETECT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [7] = '{
    REG_MOVE_INTERVAL, REG_YAW_GAIN, REG_PITCH_GAIN, REG_YAW_LOW, REG_YAW_HIGH,
    REG_PITCH_LOW, REG_PITCH_HIGH
  };

  // Deadband edges, frame edges and out-of-frame pixels
  localparam int EDGE_X [11] = '{320, 384, 385, 256, 255, 640, 0, 4095, 4095, 0, 0};
  localparam int EDGE_Y [11] = '{240, 288, 289, 192, 191, 480, 0, 4095, 4095, 0, 0};

  class pan_tilt_scoreboard;
    localparam longint SCORE_SPAN = 25600;
    localparam longint DEAD_ZONE  = 5120;
    localparam longint HALF_X     = longint'(FRAME_WIDTH / 2);
    localparam longint HALF_Y     = longint'(FRAME_HEIGHT / 2);

    typedef struct packed {
      logic [6:0]         yaw_pct;
      logic [6:0]         pitch_pct;
      logic signed [18:0] yaw_angle;
      logic signed [18:0] pitch_angle;
    } mount_move_t;

    logic [15:0]        move_interval;
    logic [13:0]        yaw_gain;
    logic [13:0]        pitch_gain;
    logic signed [18:0] yaw_lo;
    logic signed [18:0] yaw_hi;
    logic signed [18:0] pitch_lo;
    logic signed [18:0] pitch_hi;
    logic signed [18:0] yaw_held;
    logic signed [18:0] pitch_held;
    logic [16:0]        elapsed;
    mount_move_t        expected_moves [$];
    int                 mismatches;

    function new();
      move_interval = RST_MOVE_INTERVAL;
      yaw_gain      = RST_GAIN;
      pitch_gain    = RST_GAIN;
      yaw_lo        = RST_LOW_LIMIT;
      yaw_hi        = RST_HIGH_LIMIT;
      pitch_lo      = RST_LOW_LIMIT;
      pitch_hi      = RST_HIGH_LIMIT;
      yaw_held      = '0;
      pitch_held    = '0;
      elapsed       = '0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [18:0] data);
      case (idx)
        REG_MOVE_INTERVAL: move_interval = data[15:0];
        REG_YAW_GAIN:      yaw_gain      = data[13:0];
        REG_PITCH_GAIN:    pitch_gain    = data[13:0];
        REG_YAW_LOW:       yaw_lo        = data;
        REG_YAW_HIGH:      yaw_hi        = data;
        REG_PITCH_LOW:     pitch_lo      = data;
        REG_PITCH_HIGH:    pitch_hi      = data;
        default: ;
      endcase
    endfunction

    function automatic logic signed [18:0] step_axis(logic signed [18:0] held,
        logic [11:0] pixel, longint half, logic [13:0] gain,
        logic signed [18:0] lo, logic signed [18:0] hi);
      longint score;
      longint angle;
      score = (longint'(pixel) - half) * SCORE_SPAN / half;
      if (score > SCORE_SPAN) score = SCORE_SPAN;
      if (score < -SCORE_SPAN) score = -SCORE_SPAN;
      angle = longint'(held);
      if (score > DEAD_ZONE || score < -DEAD_ZONE) angle += longint'(gain) * score / 256;
      // low limit first, so the high limit wins when they cross
      if (angle < longint'(lo)) angle = longint'(lo);
      if (angle > longint'(hi)) angle = longint'(hi);
      return angle[18:0];
    endfunction

    function automatic logic [6:0] span_percent(logic signed [18:0] angle,
        logic signed [18:0] lo, logic signed [18:0] hi);
      longint span;
      longint pct;
      span = longint'(hi) - longint'(lo);
      if (span <= 0) return '0;
      pct = (longint'(angle) - longint'(lo)) * 100 / span;
      if (pct < 0) pct = 0;
      if (pct > 100) pct = 100;
      return pct[6:0];
    endfunction

    function void track_item(logic kind, logic matched, logic [11:0] x_pixel,
        logic [11:0] y_pixel);
      mount_move_t move;
      if (kind == KIND_TICK) begin
        if (elapsed != ELAPSED_MAX) elapsed++;
        return;
      end
      if (elapsed <= {1'b0, move_interval}) return;
      elapsed = '0;
      if (!matched) return;
      yaw_held   = step_axis(yaw_held, x_pixel, HALF_X, yaw_gain, yaw_lo, yaw_hi);
      pitch_held = step_axis(pitch_held, y_pixel, HALF_Y, pitch_gain, pitch_lo, pitch_hi);
      move.yaw_pct     = span_percent(yaw_held, yaw_lo, yaw_hi);
      move.pitch_pct   = span_percent(pitch_held, pitch_lo, pitch_hi);
      move.yaw_angle   = yaw_held;
      move.pitch_angle = pitch_held;
      expected_moves.push_back(move);
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task check_move(logic [6:0] yaw_pct, logic [6:0] pitch_pct,
        logic signed [18:0] yaw_angle, logic signed [18:0] pitch_angle);
      mount_move_t want;
      if (expected_moves.size() == 0) begin
        report("result transaction with no move pending");
        return;
      end
      want = expected_moves.pop_front();
      if (yaw_pct !== want.yaw_pct)
        report($sformatf("yaw percent %0d, want %0d", yaw_pct, want.yaw_pct));
      if (pitch_pct !== want.pitch_pct)
        report($sformatf("pitch percent %0d, want %0d", pitch_pct, want.pitch_pct));
      if (yaw_angle !== want.yaw_angle)
        report($sformatf("yaw angle %0d, want %0d", yaw_angle, want.yaw_angle));
      if (pitch_angle !== want.pitch_angle)
        report($sformatf("pitch angle %0d, want %0d", pitch_angle, want.pitch_angle));
    endtask

    function int pending();
      return expected_moves.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int   stall_len;

  pan_tilt_scoreboard board;

  dipt_in_if  in_ch ();
  dipt_out_if out_ch ();
  dipt_cfg_if cfg_ch ();

  deadband_integral_pan_tilt_control i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  function automatic logic [11:0] draw_pixel(int frame);
    if ($urandom_range(0, 3) != 0) return 12'($urandom_range(0, frame));
    return 12'($urandom);
  endfunction

  function automatic int draw_gain();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 10000;
      2: return int'($urandom);
      default: return int'($urandom_range(0, 10000));
    endcase
  endfunction

  // Keep the interval short so detections get through; upper data bits are junk
  function automatic int draw_interval();
    int span;
    span = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
    return span | (int'($urandom_range(0, 7)) << 16);
  endfunction

  function automatic void draw_limits(output int lo, output int hi);
    int a;
    int b;
    int mode;
    mode = $urandom_range(0, 9);
    a = int'($urandom_range(0, 360000)) - 180000;
    b = int'($urandom_range(0, 360000)) - 180000;
    if (mode < 6 && a > b || mode == 7 && a < b) begin
      lo = b;
      hi = a;
    end else begin
      lo = a;
      hi = b;
    end
    if (mode == 6) hi = lo;
    if (mode == 8) begin
      lo = int'($urandom);
      hi = int'($urandom);
    end
    if (mode == 9) begin
      lo = -180000;
      hi = 180000;
    end
  endfunction

  task automatic offer_item(logic kind, logic matched, logic [11:0] x_pixel,
      logic [11:0] y_pixel);
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.matched <= matched;
    in_ch.x_pixel <= x_pixel;
    in_ch.y_pixel <= y_pixel;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.track_item(kind, matched, x_pixel, y_pixel);
  endtask

  task automatic ticks(int count);
    repeat (count) offer_item(KIND_TICK, 1'($urandom), 12'($urandom), 12'($urandom));
  endtask

  task automatic detect(int x_pixel, int y_pixel);
    offer_item(KIND_DETECT, 1'b1, 12'(x_pixel), 12'(y_pixel));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Let an unmatched or gated detection still in flight finish as well
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(int interval, int yaw_gain, int pitch_gain, int yaw_lo,
      int yaw_hi, int pitch_lo, int pitch_hi);
    logic [18:0] values [7];
    values = '{19'(interval), 19'(yaw_gain), 19'(pitch_gain), 19'(yaw_lo), 19'(yaw_hi),
               19'(pitch_lo), 19'(pitch_hi)};
    for (int i = 0; i < 7; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= REG_ORDER[i];
      cfg_ch.data  <= values[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      board.write_reg(REG_ORDER[i], values[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(int item_count, bit pause_mid);
    int  sent;
    int  roll;
    int  run;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < item_count) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        // enough ticks to open the gate, then a detection
        run = int'(board.move_interval) + 1 + $urandom_range(0, 2);
        ticks(run);
        offer_item(KIND_DETECT, $urandom_range(0, 9) != 0, draw_pixel(FRAME_WIDTH),
                   draw_pixel(FRAME_HEIGHT));
        sent += run + 1;
      end else if (roll < 90) begin
        run = $urandom_range(0, board.move_interval);
        ticks(run);
        offer_item(KIND_DETECT, 1'($urandom), draw_pixel(FRAME_WIDTH),
                   draw_pixel(FRAME_HEIGHT));
        sent += run + 1;
      end else begin
        offer_item(1'($urandom), 1'($urandom), 12'($urandom), 12'($urandom));
        sent++;
      end
      if (pause_mid && !paused && sent >= item_count / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end
  endtask

  initial begin : result_sink
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        board.check_move(out_ch.yaw_pwm_percent, out_ch.pitch_pwm_percent,
                         out_ch.yaw_angle, out_ch.pitch_angle);
      if (stall_len != 0) begin
        hold      = stall_len;
        stall_len = 0;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= !idle_now();
      end
    end
  end

  initial begin : stimulus
    int interval;
    int yaw_gain;
    int pitch_gain;
    int yaw_lo;
    int yaw_hi;
    int pitch_lo;
    int pitch_hi;
    board     = new();
    calm      = 1'b0;
    stall_len = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= KIND_TICK;
    in_ch.matched <= 1'b0;
    in_ch.x_pixel <= '0;
    in_ch.y_pixel <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_MOVE_INTERVAL;
    cfg_ch.data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: gate opens only once the counter passes 100
    detect(0, 0);
    ticks(100);
    detect(4095, 4095);
    ticks(1);
    detect(4095, 4095);
    ticks(101);
    offer_item(KIND_DETECT, 1'b0, 12'd100, 12'd100);
    ticks(101);
    detect(0, 0);
    settle();

    // Widest limits, full gain: walk the deadband and frame edges
    write_settings(0, 10000, 10000, -180000, 180000, -180000, 180000);
    detect(320, 240);
    for (int i = 0; i < 11; i++) begin
      ticks(1);
      detect(EDGE_X[i], EDGE_Y[i]);
    end
    ticks(1);
    offer_item(KIND_DETECT, 1'b0, 12'd4095, 12'd0);
    settle();

    // Oversized gain, zero gain, empty span and crossed limits
    write_settings(0, 'h7FFFF, 0, 5000, 5000, 1000, -1000);
    for (int i = 5; i < 9; i++) begin
      ticks(1);
      detect(EDGE_X[i], EDGE_Y[i]);
    end
    settle();
    write_settings(0, 10000, 'h7FFFF, 'h40000, 'h3FFFF, 'h3FFFF, 'h40000);
    for (int i = 5; i < 9; i++) begin
      ticks(1);
      detect(EDGE_X[i], EDGE_Y[i]);
    end
    settle();

    // Junk above the 16-bit interval: six ticks open the gate, the second
    // detection right behind it is gated off
    write_settings('h70005, 1, 1, -180000, 180000, -180000, 180000);
    calm = 1'b1;
    ticks(6);
    detect(0, 4095);
    detect(4095, 0);
    calm = 1'b0;
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      interval   = (phase == 0) ? 0 : draw_interval();
      yaw_gain   = (phase == 0) ? 10000 : draw_gain();
      pitch_gain = draw_gain();
      draw_limits(yaw_lo, yaw_hi);
      draw_limits(pitch_lo, pitch_hi);
      write_settings(interval, yaw_gain, pitch_gain, yaw_lo, yaw_hi, pitch_lo, pitch_hi);
      calm = (phase == 3);
      // hold the result side off so the output register and the lanes back up
      if (phase == 0) stall_len = 400;
      random_phase(155, phase == 2);
      calm = 1'b0;
      settle();
    end

    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
